@@ hdl/ttm_pkg.sv @@
// Shared types and constants for the tick-to-microsecond timebase.
package ttm_pkg;

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_REBASE = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;
   localparam logic [1:0] MODE_DELAY  = 2'd3;

   localparam logic KIND_ELAPSED = 1'b0;
   localparam logic KIND_EXPIRY  = 1'b1;

   localparam logic [31:0] US_PER_SEC = 32'd1000000;

   // 1000000 < 2**FRAC_BITS, so the fractional quotient fits in FRAC_BITS bits
   localparam int FRAC_BITS   = 20;
   localparam int STEP_W      = 6;
   localparam int WHOLE_STEPS = 32;
   localparam int FRAC_STEPS  = FRAC_BITS / 2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] delay_us;
   } cmd_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [31:0]       rem_init;
      logic [63:0]       dividend;
      logic [31:0]       divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic        result_kind;
      logic [63:0] elapsed_us;
      logic        delay_pending;
   } rsp_type;

endpackage

@@ hdl/ttm_front.sv @@
// Front end: accepts and decodes input items into a short command queue.
module ttm_front
   import ttm_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_delay_us,
   output cmd_type     cmd,
   output logic        cmd_valid,
   input  logic        cmd_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type              entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;
   cmd_type              new_cmd;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      new_cmd.mode     = req_mode;
      new_cmd.delay_us = (req_mode == MODE_DELAY) ? req_delay_us : '0;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (push && full && !cmd_pop) |=> (count_ff == $past(count_ff)))
      else $error("queue count moved on a refused transfer");

endmodule

@@ hdl/ttm_divider.sv @@
// Iterative restoring divider, two quotient bits per cycle.
module ttm_divider
   import ttm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  req,
   output div_stat_type stat,
   output logic [63:0]  quotient,
   output logic [31:0]  remainder
);

   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [31:0]       rem_ff, rem_in;
   logic [63:0]       dvd_ff, dvd_in;
   logic [63:0]       quo_ff, quo_in;
   logic [31:0]       dsr_ff, dsr_in;
   logic [32:0]       t1, t2;
   logic [31:0]       r1, r2;
   logic              ge1, ge2;

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   always_comb begin
      t1  = {rem_ff, dvd_ff[63]};
      ge1 = (t1 >= {1'b0, dsr_ff});
      r1  = ge1 ? 32'(t1 - {1'b0, dsr_ff}) : t1[31:0];
      t2  = {r1, dvd_ff[62]};
      ge2 = (t2 >= {1'b0, dsr_ff});
      r2  = ge2 ? 32'(t2 - {1'b0, dsr_ff}) : t2[31:0];

      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         cnt_in  = req.steps;
         busy_in = 1'b1;
         rem_in  = req.rem_init;
         dvd_in  = req.dividend;
         quo_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = r2;
         dvd_in = {dvd_ff[61:0], 2'b00};
         quo_in = {quo_ff[61:0], ge1, ge2};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

endmodule

@@ hdl/ttm_back.sv @@
// Back end: timebase state, delay arming and microsecond conversion sequencer.
module ttm_back
   import ttm_pkg::*;
#(
   parameter logic [31:0] FALLBACK_HZ = 32'd24000000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] freq_hz,
   input  cmd_type     cmd,
   input  logic        cmd_valid,
   output logic        cmd_pop,
   output rsp_type     rsp,
   output logic        rsp_valid,
   input  logic        rsp_pop
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DLY_MUL = 3'd1;
   localparam logic [2:0] S_DLY_DIV = 3'd2;
   localparam logic [2:0] S_RD_DIV  = 3'd3;
   localparam logic [2:0] S_RD_FRAC = 3'd4;
   localparam logic [2:0] S_RD_LO   = 3'd5;
   localparam logic [2:0] S_RD_HI   = 3'd6;
   localparam logic [2:0] S_RD_WAIT = 3'd7;

   logic [2:0]   state_ff, state_in;
   logic [63:0]  count_ff, count_in;
   logic [63:0]  base_ff, base_in;
   logic [63:0]  target_ff, target_in;
   logic         armed_ff, armed_in;
   logic [63:0]  q_ff, q_in;
   logic [63:0]  acc_ff, acc_in;
   logic [63:0]  mul_p_ff, mul_p_in;
   logic         out_valid_ff, out_valid_in;
   rsp_type      out_ff, out_in;
   logic [31:0]  mul_a, mul_b;
   logic [31:0]  freq_eff;
   logic [63:0]  count_plus;
   logic [64:0]  target_sum;
   div_req_type  div_req;
   div_stat_type div_stat;
   logic [63:0]  div_quo;
   logic [31:0]  div_rem;
   rsp_type      expiry;

   ttm_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .req       (div_req),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign rsp       = out_ff;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      freq_eff   = (freq_hz == '0) ? FALLBACK_HZ : freq_hz;
      count_plus = count_ff + 64'd1;
      target_sum = {1'b0, count_ff} + {1'b0, div_quo};
      expiry.result_kind   = KIND_EXPIRY;
      expiry.elapsed_us    = '0;
      expiry.delay_pending = 1'b0;

      state_in     = state_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      target_in    = target_ff;
      armed_in     = armed_ff;
      q_in         = q_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      cmd_pop      = 1'b0;
      div_req      = '0;
      mul_a        = '0;
      mul_b        = '0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !out_valid_ff) begin
               cmd_pop = 1'b1;
               case (cmd.mode)
                  MODE_TICK: begin
                     count_in = count_plus;
                     if (armed_ff && (count_plus >= target_ff)) begin
                        armed_in     = 1'b0;
                        out_valid_in = 1'b1;
                        out_in       = expiry;
                     end
                  end
                  MODE_REBASE: begin
                     base_in = count_ff;
                  end
                  MODE_READ: begin
                     div_req.start    = 1'b1;
                     div_req.steps    = STEP_W'(WHOLE_STEPS);
                     div_req.rem_init = '0;
                     div_req.dividend = count_ff - base_ff;
                     div_req.divisor  = freq_eff;
                     state_in         = S_RD_DIV;
                  end
                  default: begin
                     mul_a    = freq_eff;
                     mul_b    = cmd.delay_us;
                     state_in = S_DLY_MUL;
                  end
               endcase
            end
         end
         S_DLY_MUL: begin
            div_req.start    = 1'b1;
            div_req.steps    = STEP_W'(WHOLE_STEPS);
            div_req.rem_init = '0;
            div_req.dividend = mul_p_ff;
            div_req.divisor  = US_PER_SEC;
            state_in         = S_DLY_DIV;
         end
         S_DLY_DIV: begin
            if (div_stat.done) begin
               target_in = target_sum[63:0];
               // already reached: zero ticks, or the sum wrapped below the count
               if (target_sum[64] || (div_quo == '0)) begin
                  armed_in     = 1'b0;
                  out_valid_in = 1'b1;
                  out_in       = expiry;
               end else begin
                  armed_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_RD_DIV: begin
            if (div_stat.done) begin
               q_in     = div_quo;
               mul_a    = div_rem;
               mul_b    = US_PER_SEC;
               state_in = S_RD_FRAC;
            end
         end
         S_RD_FRAC: begin
            // remainder*1e6 < f * 2**FRAC_BITS, so its upper part seeds the divider
            div_req.start    = 1'b1;
            div_req.steps    = STEP_W'(FRAC_STEPS);
            div_req.rem_init = mul_p_ff[FRAC_BITS+31:FRAC_BITS];
            div_req.dividend = {mul_p_ff[FRAC_BITS-1:0], {(64 - FRAC_BITS){1'b0}}};
            div_req.divisor  = freq_eff;
            mul_a            = q_ff[31:0];
            mul_b            = US_PER_SEC;
            state_in         = S_RD_LO;
         end
         S_RD_LO: begin
            acc_in   = mul_p_ff;
            mul_a    = q_ff[63:32];
            mul_b    = US_PER_SEC;
            state_in = S_RD_HI;
         end
         S_RD_HI: begin
            acc_in   = acc_ff + {mul_p_ff[31:0], 32'd0};
            state_in = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            if (div_stat.done) begin
               out_valid_in         = 1'b1;
               out_in.result_kind   = KIND_ELAPSED;
               out_in.elapsed_us    = acc_ff + {{(64 - FRAC_BITS){1'b0}},
                                                div_quo[FRAC_BITS-1:0]};
               out_in.delay_pending = armed_ff;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      mul_p_in = {32'd0, mul_a} * {32'd0, mul_b};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         base_ff      <= '0;
         target_ff    <= '0;
         armed_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         base_ff      <= base_in;
         target_ff    <= target_in;
         armed_ff     <= armed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      acc_ff   <= acc_in;
      mul_p_ff <= mul_p_in;
      out_ff   <= out_in;
   end

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !cmd_pop)
      else $error("command taken while sequencer busy");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> (out_valid_ff && $stable(out_ff)))
      else $error("waiting result overwritten");

   a_expiry_disarms: assert property (@(posedge clock) disable iff (reset)
      (out_valid_in && !out_valid_ff && (out_in.result_kind == KIND_EXPIRY)) |=> !armed_ff)
      else $error("delay still armed after expiry");

endmodule

@@ hdl/tick_to_microsecond_timebase.sv @@
// Top level: register port, command queue and timebase back end.
// Tick and rebase transfers pass through the queue into the timebase registers; one per cycle when
// queued, while the back end is idle and no result waits. A read runs the two-bit-per-cycle divider
// once for the whole seconds and once for the fraction; no command is taken until it is done.
// A start-delay multiplies, then runs one divider pass by 1000000; a waiting result holds the back end
// until popped. Synchronous reset clears control state, frequency, queue and result flag, not data.
module tick_to_microsecond_timebase
   import ttm_pkg::*;
#(
   parameter logic [31:0] FALLBACK_HZ = 32'd24000000,
   parameter int          QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_delay_us,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_result_kind,
   output logic [63:0] rsp_elapsed_us,
   output logic        rsp_delay_pending,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [1:0] CSR_FREQ_ADDR = 2'd0;

   logic [31:0] freq_ff, freq_in;
   cmd_type     cmd;
   logic        cmd_valid;
   logic        cmd_pop;
   rsp_type     rsp;
   logic        rsp_valid;

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_FREQ_ADDR) ? freq_ff : '0;

   always_comb begin
      freq_in = freq_ff;
      if (psel && penable && pwrite && (paddr == CSR_FREQ_ADDR)) begin
         freq_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= '0;
      end else begin
         freq_ff <= freq_in;
      end
   end

   ttm_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_mode     (req_mode),
      .req_delay_us (req_delay_us),
      .cmd          (cmd),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop)
   );

   ttm_back #(
      .FALLBACK_HZ (FALLBACK_HZ)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .freq_hz   (freq_ff),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp),
      .rsp_valid (rsp_valid),
      .rsp_pop   (pop)
   );

   assign empty             = !rsp_valid;
   assign rsp_result_kind   = rsp.result_kind;
   assign rsp_elapsed_us    = rsp.elapsed_us;
   assign rsp_delay_pending = rsp.delay_pending;

endmodule

@@ sim/tick_to_microsecond_timebase_checker.sv @@
`timescale 1ns / 100ps
// Transfer monitor, timebase predictor and result comparison for the microsecond timebase.
module tick_to_microsecond_timebase_checker
   import ttm_pkg::*;
#(
   parameter logic [1:0]  FREQ_ADDR   = 2'd0,
   parameter logic [31:0] FALLBACK_HZ = 32'd24000000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_delay_us,
   input  logic        empty,
   input  logic        pop,
   input  logic        rsp_result_kind,
   input  logic [63:0] rsp_elapsed_us,
   input  logic        rsp_delay_pending,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          fail_count,
   output int          outstanding,
   output int          commands_seen,
   output int          readings_seen,
   output int          expiries_seen
);

   localparam logic [63:0] USEC = 64'(US_PER_SEC);
   localparam rsp_type EXPIRY_RSP = '{KIND_EXPIRY, 64'd0, 1'b0};

   logic [31:0] freq_hz;
   logic [63:0] tick_total;
   logic [63:0] base_ticks;
   logic [63:0] target_ticks;
   logic        armed;
   rsp_type     awaited[$];

   function automatic logic [63:0] span_in_us(input logic [63:0] span, input logic [63:0] f);
      logic [63:0] whole;
      logic [63:0] part;
      whole = (span / f) * USEC;
      part  = ((span % f) * USEC) / f;
      return whole + part;
   endfunction

   task automatic advance_timebase(input logic [1:0] mode, input logic [31:0] us);
      logic [63:0] f;
      rsp_type     r;
      f = (freq_hz == 32'd0) ? 64'(FALLBACK_HZ) : 64'(freq_hz);
      case (mode)
         MODE_TICK: begin
            tick_total = tick_total + 64'd1;
            if (armed && tick_total >= target_ticks) begin
               armed = 1'b0;
               awaited.push_back(EXPIRY_RSP);
            end
         end
         MODE_REBASE: begin
            base_ticks = tick_total;
         end
         MODE_READ: begin
            r.result_kind   = KIND_ELAPSED;
            r.elapsed_us    = span_in_us(tick_total - base_ticks, f);
            r.delay_pending = armed;
            awaited.push_back(r);
         end
         default: begin
            target_ticks = tick_total + (f * 64'(us)) / USEC;
            if (tick_total >= target_ticks) begin
               armed = 1'b0;
               awaited.push_back(EXPIRY_RSP);
            end else begin
               armed = 1'b1;
            end
         end
      endcase
   endtask

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      commands_seen = 0;
      readings_seen = 0;
      expiries_seen = 0;
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         freq_hz      = 32'd0;
         tick_total   = 64'd0;
         base_ticks   = 64'd0;
         target_ticks = 64'd0;
         armed        = 1'b0;
         awaited.delete();
      end else begin
         if (pop && !empty) begin
            got = '{rsp_result_kind, rsp_elapsed_us, rsp_delay_pending};
            if (awaited.size() == 0) begin
               fail_count++;
               $error("unexpected result transfer: kind %0d elapsed %0d pending %0d",
                      got.result_kind, got.elapsed_us, got.delay_pending);
            end else begin
               want = awaited.pop_front();
               if (want.result_kind == KIND_ELAPSED) readings_seen++;
               else expiries_seen++;
               if (got.result_kind !== want.result_kind) begin
                  fail_count++;
                  $error("result_kind: expected %0d, got %0d",
                         want.result_kind, got.result_kind);
               end
               if (got.elapsed_us !== want.elapsed_us) begin
                  fail_count++;
                  $error("elapsed_us: expected %0d, got %0d",
                         want.elapsed_us, got.elapsed_us);
               end
               if (got.delay_pending !== want.delay_pending) begin
                  fail_count++;
                  $error("delay_pending: expected %0d, got %0d",
                         want.delay_pending, got.delay_pending);
               end
            end
         end
         if (push && !full) begin
            commands_seen++;
            advance_timebase(req_mode, req_delay_us);
         end
         if (psel && penable && pready && paddr == FREQ_ADDR) begin
            if (pwrite) begin
               freq_hz = pwdata;
            end else if (prdata !== freq_hz) begin
               fail_count++;
               $error("counter_freq_hz: expected %0d, got %0d", freq_hz, prdata);
            end
         end
      end
      outstanding = awaited.size();
   end

endmodule

@@ sim/tick_to_microsecond_timebase_test.sv @@
`timescale 1ns / 100ps
// Top-level testbench: clock, reset, command and register stimulus, and the verdict.
module tick_to_microsecond_timebase_test
   import ttm_pkg::*;
();

   localparam logic [31:0] FALLBACK   = 32'd24000000;
   localparam logic [1:0]  FREQ_ADDR  = 2'd0;
   localparam int          HOLD_CYCLES = 600;
   localparam int          PHASE_ITEMS = 322;
   localparam int          SETTLE     = 400;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_mode;
   logic [31:0] req_delay_us;
   logic        empty;
   logic        pop;
   logic        rsp_result_kind;
   logic [63:0] rsp_elapsed_us;
   logic        rsp_delay_pending;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [1:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   logic calm;
   logic stall_rsp;
   int   fail_count;
   int   outstanding;
   int   commands_seen;
   int   readings_seen;
   int   expiries_seen;
   int   settings_used;

   tick_to_microsecond_timebase #(.FALLBACK_HZ(FALLBACK)) uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_mode(req_mode), .req_delay_us(req_delay_us),
      .empty(empty), .pop(pop), .rsp_result_kind(rsp_result_kind),
      .rsp_elapsed_us(rsp_elapsed_us), .rsp_delay_pending(rsp_delay_pending),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   tick_to_microsecond_timebase_checker #(
      .FREQ_ADDR(FREQ_ADDR), .FALLBACK_HZ(FALLBACK)
   ) u_checker (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_mode(req_mode), .req_delay_us(req_delay_us),
      .empty(empty), .pop(pop), .rsp_result_kind(rsp_result_kind),
      .rsp_elapsed_us(rsp_elapsed_us), .rsp_delay_pending(rsp_delay_pending),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .fail_count(fail_count), .outstanding(outstanding), .commands_seen(commands_seen),
      .readings_seen(readings_seen), .expiries_seen(expiries_seen)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #10ms;
      $display("TEST FAILED");
      $finish;
   end

   // result side: random pop gaps, plus one long hold-off
   initial begin
      logic hold_served;
      hold_served = 1'b0;
      pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall_rsp && !hold_served) begin
            pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_served = 1'b1;
         end else begin
            pop = calm || ($urandom_range(0, 99) >= 10);
            @(negedge clock);
         end
      end
   end

   task automatic send_command(input logic [1:0] mode, input logic [31:0] us);
      while (!calm && $urandom_range(0, 99) < 10) begin
         push         = 1'b0;
         req_mode     = 2'($urandom);
         req_delay_us = $urandom;
         @(negedge clock);
      end
      push         = 1'b1;
      req_mode     = mode;
      req_delay_us = us;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      push = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = write;
      paddr   = FREQ_ADDR;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_frequency(input logic [31:0] value);
      csr_access(1'b1, value);
      csr_access(1'b0, 32'd0);
      settings_used++;
   endtask

   task automatic random_phase(input logic [31:0] freq, input logic with_hold);
      logic [63:0] f;
      logic [63:0] reach;
      logic [1:0]  mode;
      logic [31:0] us;
      int          pick;
      set_frequency(freq);
      f     = (freq == 32'd0) ? 64'(FALLBACK) : 64'(freq);
      // keep most delays within a few dozen ticks so they expire
      reach = (64'd40 * 64'(US_PER_SEC)) / f;
      if (reach > 64'hFFFF_FFFF) reach = 64'hFFFF_FFFF;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         calm = (i >= PHASE_ITEMS / 3) && (i < PHASE_ITEMS / 3 + 80);
         if (with_hold && i == PHASE_ITEMS / 2) stall_rsp = 1'b1;
         pick = $urandom_range(0, 99);
         us   = $urandom;
         if (pick < 50) mode = MODE_TICK;
         else if (pick < 60) mode = MODE_REBASE;
         else if (pick < 80) mode = MODE_READ;
         else begin
            mode = MODE_DELAY;
            if ($urandom_range(0, 7) != 0) us = $urandom_range(0, reach[31:0]);
         end
         send_command(mode, us);
      end
      calm = 1'b0;
      drain();
   endtask

   initial begin
      reset         = 1'b1;
      push          = 1'b0;
      req_mode      = MODE_TICK;
      req_delay_us  = 32'd0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = FREQ_ADDR;
      pwdata        = 32'd0;
      calm          = 1'b0;
      stall_rsp     = 1'b0;
      settings_used = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (SETTLE) @(negedge clock);

      // directed: one tick per microsecond
      set_frequency(32'd1000000);
      send_command(MODE_READ, 32'd0);
      send_command(MODE_TICK, 32'd0);
      send_command(MODE_REBASE, 32'd0);
      send_command(MODE_TICK, 32'd0);
      send_command(MODE_READ, 32'd0);
      send_command(MODE_DELAY, 32'd0);
      send_command(MODE_DELAY, 32'd2);
      send_command(MODE_READ, 32'd0);
      send_command(MODE_DELAY, 32'hFFFF_FFFF);
      send_command(MODE_DELAY, 32'd3);
      send_command(MODE_TICK, 32'd0);
      send_command(MODE_TICK, 32'd0);
      send_command(MODE_TICK, 32'd0);
      send_command(MODE_TICK, 32'd0);
      send_command(MODE_READ, 32'd0);
      send_command(MODE_DELAY, 32'd1);
      send_command(MODE_TICK, 32'hFFFF_FFFF);
      send_command(MODE_REBASE, 32'hAAAA_AAAA);
      send_command(MODE_READ, 32'h5555_5555);
      drain();

      random_phase(32'd1, 1'b0);
      random_phase(32'hFFFF_FFFF, 1'b0);
      random_phase(32'd0, 1'b1);
      random_phase($urandom, 1'b0);
      random_phase($urandom_range(1, 5000000), 1'b0);
      random_phase(32'd1000000, 1'b0);

      $display("Covered %0d commands, %0d elapsed readings and %0d expiries over %0d frequencies.",
               commands_seen, readings_seen, expiries_seen, settings_used);
      $display("Register read back after each write; result side held off once for %0d cycles.",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ tick_to_microsecond_timebase.f @@
hdl/ttm_pkg.sv
hdl/ttm_front.sv
hdl/ttm_divider.sv
hdl/ttm_back.sv
hdl/tick_to_microsecond_timebase.sv
sim/tick_to_microsecond_timebase_checker.sv
sim/tick_to_microsecond_timebase_test.sv
